@@ hw/rtl/sitoda_pkg.sv @@
`default_nettype none

package sitoda_pkg;

    // width of the signed input value
    localparam int VALUE_WIDTH = 16;

    // decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1)
    function automatic int num_digits(input int width);
        longint max_mag;
        longint pow;
        int     n;
        max_mag = longint'(1) << (width - 1);
        pow     = 10;
        n       = 1;
        while (pow <= max_mag) begin
            pow = pow * 10;
            n   = n + 1;
        end
        return n;
    endfunction

    localparam int DIGITS     = num_digits(VALUE_WIDTH);
    localparam int BCD_W      = DIGITS * 4;
    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W  = $clog2(DIGITS);
    localparam int IN_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int CHAR_W     = 7;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input, take magnitude
        logic shift;      // one double-dabble step
        logic put_sign;   // write '-' to the output register
        logic skip;       // drop a leading zero digit
        logic put_digit;  // write the top digit to the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic neg;        // input was negative
        logic conv_last;  // final conversion step this cycle
        logic top_zero;   // current top digit is zero
        logic dig_last;   // current top digit is the units digit
        logic out_free;   // output register can take a character
    } t_status;

endpackage

`default_nettype wire

@@ hw/rtl/sitoda_dp.sv @@
`default_nettype none

module sitoda_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire sitoda_pkg::t_cmd                       i_cmd,
    output sitoda_pkg::t_status                         o_status,
    input  wire logic signed [sitoda_pkg::VALUE_WIDTH-1:0] i_number,
    input  wire logic                                   i_out_ready,
    output logic                                        o_out_valid,
    output logic [sitoda_pkg::CHAR_W-1:0]               o_out_char,
    output logic                                        o_out_last
);

    localparam int W = sitoda_pkg::VALUE_WIDTH;
    localparam int B = sitoda_pkg::BCD_W;

    logic [W-1:0]                         r_mag;
    logic [B-1:0]                         r_bcd;
    logic                                 r_neg;
    logic [sitoda_pkg::BIT_CNT_W-1:0]     r_bit_cnt;
    logic [sitoda_pkg::DIG_CNT_W-1:0]     r_dig_cnt;
    logic                                 r_out_valid;
    logic [sitoda_pkg::CHAR_W-1:0]        r_out_char;
    logic                                 r_out_last;

    logic [W-1:0]  n_mag_load;
    logic [B-1:0]  n_bcd_adj;
    logic [3:0]    top_digit;
    logic          out_free;

    // magnitude of the input, the most negative value fits unsigned
    assign n_mag_load = i_number[W-1] ? W'(~i_number + 1'b1) : W'(i_number);

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < sitoda_pkg::DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                n_bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                n_bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    assign top_digit = r_bcd[B-1 -: 4];
    assign out_free  = !r_out_valid || i_out_ready;

    // conversion registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag     <= n_mag_load;
            r_neg     <= i_number[W-1];
            r_bcd     <= '0;
            r_bit_cnt <= '0;
            r_dig_cnt <= '0;
        end else if (i_cmd.shift) begin
            r_mag     <= {r_mag[W-2:0], 1'b0};
            r_bcd     <= {n_bcd_adj[B-2:0], r_mag[W-1]};
            r_bit_cnt <= r_bit_cnt + 1'b1;
        end else if (i_cmd.skip || i_cmd.put_digit) begin
            r_bcd     <= {r_bcd[B-5:0], 4'd0};
            r_dig_cnt <= r_dig_cnt + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put_sign || i_cmd.put_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_sign) begin
            r_out_char <= sitoda_pkg::CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.put_digit) begin
            r_out_char <= sitoda_pkg::CHAR_ZERO + {3'd0, top_digit};
            r_out_last <= o_status.dig_last;
        end
    end

    // status to the controller
    assign o_status.neg       = r_neg;
    assign o_status.conv_last = (r_bit_cnt == sitoda_pkg::BIT_CNT_W'(W - 1));
    assign o_status.top_zero  = (top_digit == 4'd0);
    assign o_status.dig_last  = (r_dig_cnt ==
                                 sitoda_pkg::DIG_CNT_W'(sitoda_pkg::DIGITS - 1));
    assign o_status.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

@@ hw/rtl/sitoda_ctrl.sv @@
`default_nettype none

module sitoda_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sitoda_pkg::t_status i_status,
    output sitoda_pkg::t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // command decode and next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.shift = 1'b1;
                if (i_status.conv_last) begin
                    n_state = i_status.neg ? ST_SIGN : ST_SCAN;
                end
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.put_sign = 1'b1;
                    n_state        = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // leading zeros dropped, the units digit always kept
                if (i_status.top_zero && !i_status.dig_last) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.put_digit = 1'b1;
                    if (i_status.dig_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/signed_int_to_decimal_ascii_core.sv @@
// steps: a 16-step double-dabble shift, a minus sign for a negative number,
//   then leading zero digits skipped and the remaining digits written out
// a new number is taken only in the idle state, after the last digit is written
// the output register lets the last character wait while the next number loads
// reset: synchronous active low, clears the state machine and output valid
`default_nettype none

module signed_int_to_decimal_ascii_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    // number_in
    input  wire logic [sitoda_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    // ascii_char, zero pad
    output logic [sitoda_pkg::OUT_TDATA_W-1:0]         o_m_tdata,
    output logic                                       o_m_tlast
);

    sitoda_pkg::t_cmd    cmd;
    sitoda_pkg::t_status status;
    logic [sitoda_pkg::CHAR_W-1:0] out_char;
    logic signed [sitoda_pkg::VALUE_WIDTH-1:0] number;

    assign number = i_s_tdata[sitoda_pkg::VALUE_WIDTH-1:0];

    // sequencing of conversion and character output
    sitoda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // magnitude, bcd register and output register
    sitoda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_number    (number),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_char  (out_char),
        .o_out_last  (o_m_tlast)
    );

    assign o_m_tdata = {{(sitoda_pkg::OUT_TDATA_W - sitoda_pkg::CHAR_W){1'b0}}, out_char};

    // no new number taken in the cycle after an input transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while a conversion is running");

    // every character is a minus sign or a decimal digit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (out_char == sitoda_pkg::CHAR_MINUS ||
                        (out_char >= sitoda_pkg::CHAR_ZERO &&
                         out_char <= sitoda_pkg::CHAR_ZERO + 7'd9)))
        else $error("character outside the decimal set");

    // a minus sign never ends a run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && out_char == sitoda_pkg::CHAR_MINUS) |-> !o_m_tlast)
        else $error("minus sign marked as last character");

    // a stalled character stays valid and unchanged
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output changed while stalled");

endmodule

`default_nettype wire
